// ----- src/fcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_pkg: shared definitions for the flit container deframer
// Container geometry, granule table, queue entry format and type code spans.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int CONTAINER_BYTES = 256;
    localparam int GRANULE_BYTES   = 20;
    localparam int GRANULE_COUNT   = 12;
    localparam int HDR_FIRST       = 62;
    localparam int HDR_COUNT       = 4;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TDATA_OUT_W     = 64;

    localparam logic [7:0] LAST_POS = 8'(CONTAINER_BYTES - 1);
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    // Wire position of byte 0 of each granule.
    localparam logic [7:0] GRANULE_BASE [GRANULE_COUNT] = '{
        8'd2,   8'd22,  8'd42,  8'd66,  8'd86,  8'd106,
        8'd130, 8'd150, 8'd170, 8'd194, 8'd214, 8'd234
    };

    // Message type codes that carry a span.
    localparam logic [7:0] CODE_RSP_A  = 8'h11;
    localparam logic [7:0] CODE_RSP_B  = 8'h12;
    localparam logic [7:0] CODE_REQ    = 8'h21;
    localparam logic [7:0] CODE_SNP_A  = 8'h31;
    localparam logic [7:0] CODE_SNP_B  = 8'h32;
    localparam logic [7:0] CODE_DAT2_A = 8'h41;
    localparam logic [7:0] CODE_DAT2_B = 8'h42;
    localparam logic [7:0] CODE_DAT3_A = 8'h51;
    localparam logic [7:0] CODE_DAT3_B = 8'h52;
    localparam logic [7:0] CODE_DAT5_A = 8'h61;
    localparam logic [7:0] CODE_DAT5_B = 8'h62;

    typedef enum logic [1:0] {
        ITEM_PAYLOAD = 2'd0,
        ITEM_HEADER  = 2'd1,
        ITEM_SUMMARY = 2'd2
    } t_item_kind;

    // For a header entry the offset field carries the header byte index.
    typedef struct packed {
        t_item_kind  kind;
        logic [3:0]  granule;
        logic [4:0]  offset;
        logic [7:0]  data;
    } t_qentry;

    // Number of granules a message of this type occupies; zero for response
    // codes and for codes that are not recognised.
    function automatic logic [2:0] span_of(input logic [7:0] code);
        logic [2:0] n;
        case (code)
            CODE_REQ, CODE_SNP_A, CODE_SNP_B: n = 3'd1;
            CODE_DAT2_A, CODE_DAT2_B:         n = 3'd2;
            CODE_DAT3_A, CODE_DAT3_B:         n = 3'd3;
            CODE_DAT5_A, CODE_DAT5_B:         n = 3'd5;
            CODE_RSP_A, CODE_RSP_B:           n = 3'd0;
            default:                          n = 3'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- src/fcd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_front: byte position tracking and classification
// Counts wire positions and turns each accepted payload, header or last byte into a queue entry.
// ----------------------------------------------------------------------------
module fcd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [7:0]      i_s_tdata,
    input  wire logic            i_queue_full,
    output logic                 o_push,
    output fcd_pkg::t_qentry     o_entry
);

    logic [7:0] r_pos;
    logic [7:0] n_pos;
    logic       accept;
    logic       found;
    logic [3:0] gran;
    logic [7:0] diff;
    logic [7:0] hdr_diff;

    assign o_s_tready = !i_queue_full;
    assign accept     = i_s_tvalid && !i_queue_full;
    assign hdr_diff   = r_pos - 8'(fcd_pkg::HDR_FIRST);

    // Twelve independent range checks; at most one can match.
    always_comb begin
        found = 1'b0;
        gran  = '0;
        diff  = '0;
        for (int g = 0; g < fcd_pkg::GRANULE_COUNT; g++) begin
            if (!found && r_pos >= fcd_pkg::GRANULE_BASE[g] &&
                (r_pos - fcd_pkg::GRANULE_BASE[g]) < 8'(fcd_pkg::GRANULE_BYTES)) begin
                found = 1'b1;
                gran  = 4'(g);
                diff  = r_pos - fcd_pkg::GRANULE_BASE[g];
            end
        end
    end

    always_comb begin
        o_push         = 1'b0;
        o_entry.kind   = fcd_pkg::ITEM_PAYLOAD;
        o_entry.granule = '0;
        o_entry.offset = '0;
        o_entry.data   = i_s_tdata;
        if (r_pos == fcd_pkg::LAST_POS) begin
            o_push       = accept;
            o_entry.kind = fcd_pkg::ITEM_SUMMARY;
            o_entry.data = '0;
        end else if (hdr_diff < 8'(fcd_pkg::HDR_COUNT)) begin
            o_push         = accept;
            o_entry.kind   = fcd_pkg::ITEM_HEADER;
            o_entry.offset = 5'(hdr_diff);
        end else if (found) begin
            o_push          = accept;
            o_entry.granule = gran;
            o_entry.offset  = diff[4:0];
        end
    end

    // The counter wraps from the last position back to zero by itself.
    assign n_pos = accept ? r_pos + 8'd1 : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ----- src/fcd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_queue: small first-in first-out queue of classified entries
// Decouples classification from result generation.
// ----------------------------------------------------------------------------
module fcd_queue #(
    parameter int DEPTH = fcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fcd_pkg::t_qentry i_entry,
    output logic                  o_full,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output fcd_pkg::t_qentry      o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    fcd_pkg::t_qentry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- src/fcd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_back: container state and result generation
// Records header bytes, type codes and nonzero flags, forms payload and
// summary results and holds them in the output register.
// ----------------------------------------------------------------------------
module fcd_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_queue_empty,
    input  wire fcd_pkg::t_qentry               i_entry,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [fcd_pkg::TDATA_OUT_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser
);

    localparam int GC = fcd_pkg::GRANULE_COUNT;

    logic [7:0]    r_hdr  [fcd_pkg::HDR_COUNT];
    logic [7:0]    r_code [GC];
    logic [GC-1:0] r_nonzero;
    logic          r_valid, n_valid;
    logic          r_kind;
    logic [fcd_pkg::TDATA_OUT_W-1:0] r_data;

    logic          out_free;
    logic          is_hdr, is_pay, is_sum;
    logic [11:0]   smask;
    logic [11:0]   occ;
    logic [3:0]    rq, rs, dt, sn;
    logic          cvalid;
    logic [2:0]    span;
    logic [fcd_pkg::TDATA_OUT_W-1:0] pay_word, sum_word;

    assign out_free = !r_valid || i_m_tready;
    assign is_hdr   = (i_entry.kind == fcd_pkg::ITEM_HEADER);
    assign is_pay   = (i_entry.kind == fcd_pkg::ITEM_PAYLOAD);
    assign is_sum   = (i_entry.kind == fcd_pkg::ITEM_SUMMARY);
    // Header entries need no output slot, so they drain even under a stall.
    assign o_pop    = !i_queue_empty && (is_hdr || out_free);

    assign rq     = r_hdr[0][3:0];
    assign rs     = r_hdr[0][7:4];
    assign dt     = r_hdr[1][3:0];
    assign sn     = r_hdr[1][7:4];
    assign smask  = {r_hdr[3][3:0] & fcd_pkg::NIBBLE_MASK, r_hdr[2]};
    assign cvalid = (smask != '0) || (rq != '0) || (rs != '0) ||
                    (dt != '0) || (sn != '0);

    // A start granule always counts; a known span is marked only when it
    // fits inside the container.
    always_comb begin
        occ  = r_nonzero;
        span = '0;
        for (int g = 0; g < GC; g++) begin
            span = fcd_pkg::span_of(r_code[g]);
            if (smask[g]) begin
                occ[g] = 1'b1;
                if (span != '0 && (g + int'(span)) <= GC) begin
                    for (int k = 0; k < 5; k++) begin
                        if (k < int'(span) && (g + k) < GC) begin
                            occ[g + k] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign pay_word = {{(fcd_pkg::TDATA_OUT_W - 17){1'b0}},
                       i_entry.data, i_entry.offset, i_entry.granule};
    assign sum_word = {{(fcd_pkg::TDATA_OUT_W - 58){1'b0}},
                       cvalid, occ, smask, sn, dt, rs, rq, 17'b0};

    always_comb begin
        n_valid = r_valid;
        if (i_m_tready) begin
            n_valid = 1'b0;
        end
        if (o_pop && !is_hdr) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !is_hdr) begin
            r_kind <= is_sum;
            r_data <= is_sum ? sum_word : pay_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_nonzero <= '0;
            for (int h = 0; h < fcd_pkg::HDR_COUNT; h++) begin
                r_hdr[h] <= '0;
            end
            for (int g = 0; g < GC; g++) begin
                r_code[g] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                if (is_sum) begin
                    r_nonzero <= '0;
                    for (int h = 0; h < fcd_pkg::HDR_COUNT; h++) begin
                        r_hdr[h] <= '0;
                    end
                    for (int g = 0; g < GC; g++) begin
                        r_code[g] <= '0;
                    end
                end else if (is_hdr) begin
                    r_hdr[i_entry.offset[1:0]] <= i_entry.data;
                end else if (is_pay) begin
                    if (i_entry.offset == '0) begin
                        r_code[i_entry.granule] <= i_entry.data;
                    end
                    if (i_entry.data != '0) begin
                        r_nonzero[i_entry.granule] <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_kind;

endmodule
`default_nettype wire

// ----- src/flit_container_deframer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// flit_container_deframer_top: link container deframer
// Unpacks 256-byte containers arriving one byte per transfer into granule
// payload bytes and one summary per container.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+--------------------------------------------------
//  s       | in        | tdata[7:0] wire byte
//  m       | out       | tuser kind, tdata granule/offset/data and summary
//
// One byte is accepted per cycle unless the queue is full; a payload byte,
// a header byte or the last byte of a container is written into the queue
// in the same cycle as its transfer, and any other byte is dropped there.
// The back end moves one entry a cycle into the single output register when
// it is free (headers skip it), so the sustained rate is one byte per cycle.
// Reset is synchronous and active low; it sets the byte position to zero,
// clears all captured header, type code and occupancy state and empties
// the queue. A stall on the output fills the queue; once it is full the
// input is held off, and header bytes keep draining regardless.
//
module flit_container_deframer_top #(
    parameter int QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata fields from bit 0: wire_byte[7:0]
    input  wire logic [7:0]                     s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata fields from bit 0: granule_index[3:0], byte_offset[8:4],
    // data_byte[16:9], req_credit[20:17], rsp_credit[24:21],
    // dat_credit[28:25], snp_credit[32:29], start_mask[44:33],
    // occupied_mask[56:45], container_valid[57], zero fill [63:58]
    output logic [fcd_pkg::TDATA_OUT_W-1:0]     m_tdata,
    // tuser fields from bit 0: kind[0]
    output logic                                m_tuser
);

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    fcd_pkg::t_qentry q_in;
    fcd_pkg::t_qentry q_out;

    // Front end: position counter and byte classification.
    fcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    // Queue between classification and result generation.
    fcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_entry (q_out)
    );

    // Back end: container state, summary evaluation and output register.
    fcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (q_empty),
        .i_entry       (q_out),
        .o_pop         (q_pop),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire
